### design/assert_macros.svh
// Assertion macros shared by the printable run extractor modules.
// Included by the controller and datapath files; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
`define PRE_NEVER(lbl, clk, rst_n, expr) \
    `PRE_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define PRE_ASSERT(lbl, clk, rst_n, prop)
`define PRE_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### design/pre_pkg.sv
// Shared types and constants of the printable run extractor.
// Used by pre_ctrl, pre_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package pre_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 7;
    localparam int MIN_LEN_RST = 4;

    localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;
    localparam logic [BYTE_W-1:0] NEWLINE  = 8'h0A;

    typedef struct packed {
        logic capture;
        logic store;
        logic set_emit;
        logic clear_run;
        logic load_pass;
        logic load_nl;
        logic load_flush;
        logic idx_clr;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        logic printable;
        logic emitting;
        logic hits_min;
        logic out_free;
        logic flush_last;
    } t_sts;

endpackage

### design/printable_run_extractor_unit.sv
// Top level of the printable run extractor: controller plus datapath.
// Depends on pre_pkg, pre_ctrl and pre_dp.
`timescale 1ns / 1ps

// Takes one byte per word and reports runs of printable bytes (0x20..0x7E) at
// least min_length long, strings-style: a run is held until it reaches
// min_length, then flushed as one burst whose final word has tlast, later
// printable bytes pass straight through, and the first non-printable byte
// after a reported run emits a newline (0x0A). Feed byte 0 to close the last
// run. Each input word is captured, then decided, waiting only if it must load
// a busy output register; no word is taken before that. A flush reads each held
// byte through the registered read of the run buffer, and input is not taken
// until the burst has been handed to the output register. min_length is
// written through i_cfg_we / i_cfg_wdata; 0 reads as 1, values above MAX_RUN
// saturate to MAX_RUN; reset value 4.
module printable_run_extractor_unit #(
    parameter int MAX_RUN = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pre_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [pre_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [pre_pkg::BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast
);
    import pre_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pre_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    pre_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_byte   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

### design/pre_ctrl.sv
// Controller of the printable run extractor: sequences accept, decide and flush.
// Depends on pre_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pre_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  pre_pkg::t_sts i_sts,
    output pre_pkg::t_cmd o_cmd
);
    import pre_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_EXEC     = 4'b0010,
        S_FLUSH_RD = 4'b0100,
        S_FLUSH_WR = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.printable) begin
                    if (i_sts.emitting) begin
                        if (i_sts.out_free) begin
                            cmd.load_pass = 1'b1;
                            n_state       = S_IDLE;
                        end
                    end else begin
                        cmd.store = 1'b1;
                        if (i_sts.hits_min) begin
                            cmd.set_emit = 1'b1;
                            cmd.idx_clr  = 1'b1;
                            n_state      = S_FLUSH_RD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (i_sts.emitting) begin
                    if (i_sts.out_free) begin
                        cmd.load_nl   = 1'b1;
                        cmd.clear_run = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    cmd.clear_run = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_FLUSH_RD: begin
                n_state = S_FLUSH_WR;
            end
            S_FLUSH_WR: begin
                if (i_sts.out_free) begin
                    cmd.load_flush = 1'b1;
                    if (i_sts.flush_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        n_state     = S_FLUSH_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd           = cmd;
    assign o_s_axis_tready = (r_state == S_IDLE);

    `PRE_ASSERT(a_flush_start, i_clk, i_rst_n,
        (r_state == S_EXEC && i_sts.printable && !i_sts.emitting && i_sts.hits_min)
        |=> (r_state == S_FLUSH_RD))
    `PRE_ASSERT(a_rd_then_wr, i_clk, i_rst_n,
        (r_state == S_FLUSH_RD) |=> (r_state == S_FLUSH_WR))
    `PRE_NEVER(a_no_out_busy, i_clk, i_rst_n,
        (o_cmd.load_pass || o_cmd.load_nl || o_cmd.load_flush) && !i_sts.out_free)

endmodule

### design/pre_dp.sv
// Datapath of the printable run extractor: run buffer, counters, config and output word.
// Depends on pre_pkg and assert_macros.svh; driven by pre_ctrl commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pre_dp #(
    parameter int MAX_RUN = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pre_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [pre_pkg::BYTE_W-1:0]   i_in_byte,
    input  pre_pkg::t_cmd                i_cmd,
    output pre_pkg::t_sts                o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [pre_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_out_last
);
    import pre_pkg::*;

    localparam int CNT_W   = $clog2(MAX_RUN + 1);
    localparam int IDX_W   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int CMP_W   = CFG_W + 1;
    localparam int MIN_RST = (MIN_LEN_RST > MAX_RUN) ? MAX_RUN : MIN_LEN_RST;

    logic [BYTE_W-1:0] r_mem [MAX_RUN];
    logic [BYTE_W-1:0] r_in_byte;
    logic [BYTE_W-1:0] r_rd_data;
    logic [CNT_W-1:0]  r_run_cnt;
    logic [CNT_W-1:0]  n_run_cnt;
    logic              r_emit;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [CFG_W-1:0]  r_min_len;
    logic [CFG_W-1:0]  n_min_len;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              store_ok;

    assign store_ok = (r_run_cnt < CNT_W'(MAX_RUN));
    assign n_run_cnt = store_ok ? (r_run_cnt + CNT_W'(1)) : r_run_cnt;

    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            n_min_len = CFG_W'(1);
        end else if (i_cfg_wdata > CFG_W'(MAX_RUN)) begin
            n_min_len = CFG_W'(MAX_RUN);
        end else begin
            n_min_len = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= CFG_W'(MIN_RST);
        end else if (i_cfg_we) begin
            r_min_len <= n_min_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && store_ok) begin
            r_mem[r_run_cnt[IDX_W-1:0]] <= r_in_byte;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt <= '0;
            r_emit    <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            if (i_cmd.clear_run) begin
                r_run_cnt <= '0;
                r_emit    <= 1'b0;
            end else begin
                if (i_cmd.store) begin
                    r_run_cnt <= n_run_cnt;
                end
                if (i_cmd.set_emit) begin
                    r_emit <= 1'b1;
                end
            end
            if (i_cmd.idx_clr) begin
                r_rd_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_pass || i_cmd.load_nl || i_cmd.load_flush) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load_pass) begin
            r_out_byte <= r_in_byte;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_nl) begin
            r_out_byte <= NEWLINE;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_flush) begin
            r_out_byte <= r_rd_data;
            r_out_last <= o_sts.flush_last;
        end else begin
            r_out_byte <= r_out_byte;
            r_out_last <= r_out_last;
        end
    end

    assign o_sts.printable  = (r_in_byte >= PRINT_LO) && (r_in_byte <= PRINT_HI);
    assign o_sts.emitting   = r_emit;
    assign o_sts.hits_min   = (CMP_W'(n_run_cnt) >= CMP_W'(r_min_len));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.flush_last = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_run_cnt);

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    `PRE_NEVER(a_cnt_max, i_clk, i_rst_n, r_run_cnt > CNT_W'(MAX_RUN))
    `PRE_NEVER(a_min_rng, i_clk, i_rst_n,
        (r_min_len == '0) || (r_min_len > CFG_W'(MAX_RUN)))
    `PRE_ASSERT(a_flush_run, i_clk, i_rst_n,
        i_cmd.load_flush |-> (r_emit && (r_run_cnt != '0)))
    `PRE_ASSERT(a_clear, i_clk, i_rst_n,
        i_cmd.clear_run |=> ((r_run_cnt == '0) && !r_emit))

endmodule
